// ===== design/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants of the delimiter token splitter
// Holds the register map and the delimiter setup that the register block
// hands to the datapath.
// ----------------------------------------------------------------------------
package dts_pkg;

    // Register map: the register index is bit 2 of the byte address.
    localparam int  ADDR_W            = 3;
    localparam int  DATA_W            = 32;
    localparam logic REG_DELIM_BYTES  = 1'b0;
    localparam logic REG_DELIM_LENGTH = 1'b1;

    // Values after reset: CR LF, two bytes.
    localparam logic [31:0] DELIM_BYTES_RST  = 32'h0000_0A0D;
    localparam logic [2:0]  DELIM_LENGTH_RST = 3'd2;

    // Widest value of an output offset or length field.
    localparam logic [31:0] FIELD16_MAX = 32'h0000_FFFF;

    // Delimiter setup seen by the datapath.
    typedef struct packed {
        logic [31:0] bytes;   // first delimiter byte in bits 7:0
        logic [2:0]  length;  // effective length, always 1 to the cap
    } dlm_cfg_t;

endpackage

// ===== design/delimiter_token_splitter.sv =====
// ----------------------------------------------------------------------------
// delimiter_token_splitter: splits a byte stream into delimited tokens
// One byte per transfer in, one token descriptor per delimiter match or
// buffer end out.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and gives each result in the cycle
// after the byte that causes it. The window compare, the offset counters and
// the output register all update in the same cycle, so a byte can be
// taken in every cycle for as long as the result side keeps m_tready high;
// while a result waits, the input is held off. A token result carries its
// start offset and length; the last token of a buffer has m_tlast set, and
// m_tuser flags a buffer that ran past MAX_BYTES bytes, with offsets and
// lengths saturated at 65535. The delimiter is set through the APB port at
// byte address 0 (bytes, first in bits 7:0) and 4 (length, 1 to 4); the user
// must set it only while no buffer is in progress, as the block does not enforce it.
module delimiter_token_splitter #(
    parameter int MAX_BYTES = 65536,
    parameter int DELIM_MAX = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Input bytes.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  logic                       s_tlast,   // final_byte
    // Token results.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // [15:0] token_start, [31:16] token_length
    output logic                       m_tlast,   // end_of_buffer
    output logic                       m_tuser,   // [0] too_long
    // Configuration.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dts_pkg::ADDR_W-1:0] paddr,
    input  logic [dts_pkg::DATA_W-1:0] pwdata,
    output logic [dts_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int           PW    = $clog2(MAX_BYTES + 1);
    localparam logic [PW-1:0] MAX_P = PW'(MAX_BYTES);

    dts_pkg::dlm_cfg_t cfg;

    logic [31:0]   recent_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] tbegin_reg;
    logic          ovf_reg;

    logic          m_valid_reg;
    logic [15:0]   start_reg;
    logic [15:0]   length_reg;
    logic          eob_reg;
    logic          long_reg;

    logic          s_accept;
    logic [31:0]   recent_next;
    logic [3:0]    hit;
    logic [1:0]    len_idx;
    logic [PW:0]   span;
    logic [PW:0]   len_w;
    logic          match;
    logic          emit;
    logic          ovf_next;
    logic [PW:0]   pos_inc;
    logic [PW-1:0] tbegin_next;
    logic [PW:0]   tok_len;

    // Clamp a count to the 16-bit output field.
    function automatic logic [15:0] sat16(input logic [PW:0] v);
        if (32'(v) > dts_pkg::FIELD16_MAX) begin
            return 16'hFFFF;
        end
        return 16'(v);
    endfunction

    dts_cfg #(
        .DELIM_MAX (DELIM_MAX)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A byte can enter when the output register is empty or being emptied.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Shift the new byte into the top of the window.
    assign recent_next = {s_tdata, recent_reg[31:8]};

    // Compare the newest L window bytes with the delimiter, for each L.
    always_comb begin
        for (int l = 1; l <= 4; l++) begin
            hit[l-1] = 1'b1;
            for (int j = 0; j < l; j++) begin
                if (recent_next[8*(4-l+j) +: 8] != cfg.bytes[8*j +: 8]) begin
                    hit[l-1] = 1'b0;
                end
            end
        end
    end

    // Token bookkeeping: a match must lie wholly inside the current token.
    always_comb begin
        len_idx     = 2'(cfg.length - 3'd1);
        len_w       = (PW+1)'(cfg.length);
        pos_inc     = {1'b0, pos_reg} + 1'b1;
        span        = pos_inc - {1'b0, tbegin_reg};
        match       = (span >= len_w) && hit[len_idx];
        emit        = match || s_tlast;
        ovf_next    = ovf_reg || (pos_reg >= MAX_P);
        tok_len     = match ? (span - len_w) : span;
        if (pos_inc > {1'b0, MAX_P}) begin
            tbegin_next = MAX_P;
        end else begin
            tbegin_next = pos_inc[PW-1:0];
        end
    end

    // Stream state; the final byte returns it to the start of a buffer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg <= '0;
            pos_reg    <= '0;
            tbegin_reg <= '0;
            ovf_reg    <= 1'b0;
        end else if (s_accept) begin
            if (s_tlast) begin
                recent_reg <= '0;
                pos_reg    <= '0;
                tbegin_reg <= '0;
                ovf_reg    <= 1'b0;
            end else begin
                recent_reg <= recent_next;
                ovf_reg    <= ovf_next;
                if (pos_reg < MAX_P) begin
                    pos_reg <= pos_inc[PW-1:0];
                end
                if (match) begin
                    tbegin_reg <= tbegin_next;
                end
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= emit;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            start_reg  <= sat16({1'b0, tbegin_reg});
            length_reg <= sat16(tok_len);
            eob_reg    <= s_tlast;
            long_reg   <= ovf_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {length_reg, start_reg};
    assign m_tlast  = eob_reg;
    assign m_tuser  = long_reg;

    // The final byte always yields a closing token in the next cycle.
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> m_tvalid && m_tlast)
        else $error("final byte did not produce an end-of-buffer token");

    // The final byte returns the stream state to the start of a buffer.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> pos_reg == '0 && tbegin_reg == '0 && !ovf_reg)
        else $error("stream state not cleared after final byte");

    // The current token never starts past the incoming byte.
    a_begin_order: assert property (@(posedge aclk) disable iff (!aresetn)
        tbegin_reg <= pos_reg)
        else $error("token start ahead of byte position");

endmodule

// ===== design/dts_cfg.sv =====
// ----------------------------------------------------------------------------
// dts_cfg: configuration registers of the delimiter token splitter
// APB-style register file for the delimiter bytes and length, with the
// length clamped to the range that the window supports.
// ----------------------------------------------------------------------------
module dts_cfg #(
    parameter int DELIM_MAX = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dts_pkg::ADDR_W-1:0] paddr,
    input  logic [dts_pkg::DATA_W-1:0] pwdata,
    output logic [dts_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output dts_pkg::dlm_cfg_t          cfg
);

    // The window holds four bytes, so the cap never exceeds four.
    localparam int          CAP   = (DELIM_MAX < 4) ? DELIM_MAX : 4;
    localparam logic [2:0]  CAP_L = 3'(CAP);

    logic [31:0] delim_bytes_reg;
    logic [2:0]  delim_length_reg;
    logic        wr_en;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes at the access phase of a transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_bytes_reg  <= dts_pkg::DELIM_BYTES_RST;
            delim_length_reg <= dts_pkg::DELIM_LENGTH_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                dts_pkg::REG_DELIM_BYTES:  delim_bytes_reg  <= pwdata;
                dts_pkg::REG_DELIM_LENGTH: delim_length_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Read back the stored values.
    always_comb begin
        unique case (reg_idx)
            dts_pkg::REG_DELIM_BYTES:  prdata = delim_bytes_reg;
            dts_pkg::REG_DELIM_LENGTH: prdata = {29'd0, delim_length_reg};
            default:                   prdata = '0;
        endcase
    end

    // A length of zero acts as one; anything past the cap is cut to it.
    always_comb begin
        cfg.bytes = delim_bytes_reg;
        if (delim_length_reg == 3'd0) begin
            cfg.length = 3'd1;
        end else if (delim_length_reg > CAP_L) begin
            cfg.length = CAP_L;
        end else begin
            cfg.length = delim_length_reg;
        end
    end

endmodule

// ===== sim/delimiter_token_splitter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delimiter_token_splitter_tb: self-checking bench for the token splitter
// Streams byte buffers into the splitter and predicts every token result
// from its own copy of the window, the offsets and the delimiter setup.
// Each result transfer is compared field by field with the oldest
// prediction. The run covers directed corner cases and every length code,
// then random buffers rich in delimiters, and then an unbroken stream.
// Both stream sides idle at random only during the random buffers.
// ----------------------------------------------------------------------------
module delimiter_token_splitter_tb;

    localparam int MAX_BYTES = 65536;
    localparam int DELIM_MAX = 4;

    localparam logic [dts_pkg::ADDR_W-1:0] ADDR_DELIM_BYTES  =
        {dts_pkg::REG_DELIM_BYTES, 2'b00};
    localparam logic [dts_pkg::ADDR_W-1:0] ADDR_DELIM_LENGTH =
        {dts_pkg::REG_DELIM_LENGTH, 2'b00};

    // One token descriptor as the result side carries it.
    typedef struct packed {
        logic [15:0] tok_start;
        logic [15:0] tok_length;
        logic        eob;
        logic        too_long;
    } token_t;

    typedef logic [7:0] byte_seq_t[$];

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [7:0]                 s_tdata;   // [7:0] data_byte
    logic                       s_tlast;   // final_byte
    logic                       m_tvalid;
    logic                       m_tready;
    logic [31:0]                m_tdata;   // [15:0] token_start, [31:16] token_length
    logic                       m_tlast;   // end_of_buffer
    logic                       m_tuser;   // [0] too_long
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [dts_pkg::ADDR_W-1:0] paddr;
    logic [dts_pkg::DATA_W-1:0] pwdata;
    logic [dts_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    // Delimiter setup as last written, and the predicted stream state.
    logic [31:0] delim_bytes   = dts_pkg::DELIM_BYTES_RST;
    logic [2:0]  delim_code    = dts_pkg::DELIM_LENGTH_RST;
    logic [31:0] window        = '0;
    logic [16:0] byte_pos      = '0;
    logic [16:0] tok_begin     = '0;
    logic        overflow_seen = 1'b0;

    token_t pending_tokens[$];

    // Idling controls for the input and result sides.
    bit src_idle  = 1'b0;
    bit sink_idle = 1'b0;

    int unsigned mismatches     = 0;
    int unsigned tokens_checked = 0;
    int unsigned bytes_sent     = 0;
    int unsigned buffers_sent   = 0;

    delimiter_token_splitter #(
        .MAX_BYTES(MAX_BYTES),
        .DELIM_MAX(DELIM_MAX)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 aclk = ~aclk;

    // Delimiter length in use: code 0 acts as 1, large codes are capped.
    function automatic int unsigned active_delim_len();
        int unsigned n;
        int unsigned cap;
        n = 32'(delim_code);
        cap = (DELIM_MAX < 4) ? DELIM_MAX : 4;
        if (n == 0) begin
            n = 1;
        end
        if (n > cap) begin
            n = cap;
        end
        return n;
    endfunction

    function automatic logic [15:0] clip16(input int unsigned v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    // Advances the predicted stream by one byte; returns 1 when it yields a token.
    function automatic bit predict_token(input logic [7:0] data, input logic last,
                                         output token_t tok);
        int unsigned n;
        int unsigned idx;
        int unsigned mask;
        int unsigned tail;
        int unsigned span;
        int unsigned t_len;
        int unsigned begin_u;
        bit          hit;
        n = active_delim_len();
        idx = 32'(byte_pos);
        begin_u = 32'(tok_begin);
        mask = (n >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 1);
        if (idx >= MAX_BYTES) begin
            overflow_seen = 1'b1;
        end
        window = {data, window[31:8]};
        tail = (window >> (8 * (4 - n))) & mask;
        span = idx + 1 - begin_u;
        hit = (span >= n) && (tail == (delim_bytes & mask));
        tok.tok_start = clip16(begin_u);
        t_len = span;
        if (hit) begin
            t_len = idx + 1 - n - begin_u;
            tok_begin = (idx + 1 > MAX_BYTES) ? 17'(MAX_BYTES) : 17'(idx + 1);
        end
        tok.tok_length = clip16(t_len);
        tok.eob = last;
        tok.too_long = overflow_seen;
        // The final byte returns the stream to its start for the next buffer.
        if (last) begin
            window = '0;
            byte_pos = '0;
            tok_begin = '0;
            overflow_seen = 1'b0;
        end else if (idx < MAX_BYTES) begin
            byte_pos = byte_pos + 17'd1;
        end
        return hit || last;
    endfunction

    // Random buffer built mostly from delimiter pieces, with random filler.
    function automatic void make_buffer(output byte_seq_t seq);
        int unsigned n;
        int unsigned target;
        int unsigned pick;
        int unsigned cut;
        n = active_delim_len();
        target = $urandom_range(1, 24);
        seq = {};
        while (seq.size() < target) begin
            pick = $urandom_range(0, 9);
            if (pick <= 2) begin
                for (int k = 0; k < n; k++) begin
                    seq.push_back(delim_bytes[8 * k +: 8]);
                end
            end else if (pick == 3 && n > 1) begin
                cut = $urandom_range(1, n - 1);
                for (int k = 0; k < cut; k++) begin
                    seq.push_back(delim_bytes[8 * k +: 8]);
                end
            end else if (pick <= 5) begin
                seq.push_back(delim_bytes[8 * $urandom_range(0, n - 1) +: 8]);
            end else begin
                seq.push_back(8'($urandom_range(0, 255)));
            end
        end
        // Half of the buffers end on a whole delimiter.
        if ($urandom_range(0, 1) == 1) begin
            for (int k = 0; k < n; k++) begin
                seq.push_back(delim_bytes[8 * k +: 8]);
            end
        end
    endfunction

    // Offers one byte and waits for its transfer, then records the prediction.
    task automatic send_byte(input logic [7:0] data, input logic last);
        token_t tok;
        int unsigned gap;
        if (src_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (last) begin
            buffers_sent++;
        end
        if (predict_token(data, last, tok)) begin
            pending_tokens.push_back(tok);
        end
    endtask

    task automatic send_buffer(input byte_seq_t seq);
        for (int i = 0; i < seq.size(); i++) begin
            send_byte(seq[i], i == seq.size() - 1);
        end
    endtask

    // Stops the input and waits until every predicted token has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [dts_pkg::ADDR_W-1:0] addr,
                                  input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DELIM_BYTES) begin
            delim_bytes = value;
        end else if (addr == ADDR_DELIM_LENGTH) begin
            delim_code = value[2:0];
        end
    endtask

    task automatic set_delimiter(input logic [31:0] pattern, input logic [2:0] code);
        write_register(ADDR_DELIM_BYTES, pattern);
        write_register(ADDR_DELIM_LENGTH, {29'd0, code});
    endtask

    // CR LF after reset: empty tokens, a match on the final byte, short buffers.
    task automatic test_default_delimiter();
        send_buffer('{8'h0D, 8'h0A, 8'h41, 8'h0D, 8'h0A, 8'h0D, 8'h0D, 8'h0A, 8'hFF,
                      8'h00});
        send_buffer('{8'h0A});
        send_buffer('{8'h58, 8'h0D, 8'h0A});
        send_buffer('{8'h0D, 8'h0A});
        wait_drained();
    endtask

    // A self-overlapping delimiter must not match across the previous match.
    task automatic test_overlapping_delimiter();
        set_delimiter(32'h0000_4141, 3'd2);
        send_buffer('{8'h41, 8'h41, 8'h41, 8'h41, 8'h41});
        wait_drained();
    endtask

    // Every length code, all-zero and all-one delimiters, random content.
    task automatic test_random_buffers();
        logic [31:0] pattern;
        logic [2:0]  code;
        logic [7:0]  b0;
        logic [7:0]  b1;
        byte_seq_t   seq;
        int unsigned phase_start;
        for (int ph = 0; ph < 14; ph++) begin
            b0 = 8'($urandom_range(0, 255));
            b1 = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
                0: pattern = $urandom;
                1: pattern = {4{b0}};
                default: pattern = {b1, b0, b0, b0};
            endcase
            code = (ph < 8) ? ph[2:0] : 3'($urandom_range(0, 7));
            if (ph == 8) begin
                pattern = 32'h0000_0000;
                code = 3'd4;
            end else if (ph == 9) begin
                pattern = 32'hFFFF_FFFF;
                code = 3'd7;
            end
            set_delimiter(pattern, code);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 30) begin
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
                make_buffer(seq);
                send_buffer(seq);
            end
            wait_drained();
        end
    endtask

    // A few random buffers back to back with both sides always ready.
    task automatic test_unbroken_stream();
        byte_seq_t seq;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        set_delimiter($urandom, 3'($urandom_range(1, 4)));
        repeat (6) begin
            make_buffer(seq);
            send_buffer(seq);
        end
        wait_drained();
    endtask

    // Result side: random stall bursts while idling is enabled.
    initial begin : token_sink
        int unsigned hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold != 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest predicted token.
    always @(posedge aclk) begin
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                $error("Token result with none predicted: start %0d length %0d",
                       m_tdata[15:0], m_tdata[31:16]);
                mismatches++;
            end else begin
                want = pending_tokens.pop_front();
                tokens_checked++;
                if (m_tdata[15:0] !== want.tok_start) begin
                    $error("token_start: expected %0d, got %0d", want.tok_start,
                           m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[31:16] !== want.tok_length) begin
                    $error("token_length: expected %0d, got %0d", want.tok_length,
                           m_tdata[31:16]);
                    mismatches++;
                end
                if (m_tlast !== want.eob) begin
                    $error("end_of_buffer: expected %0d, got %0d", want.eob, m_tlast);
                    mismatches++;
                end
                if (m_tuser !== want.too_long) begin
                    $error("too_long: expected %0d, got %0d", want.too_long, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_delimiter();
        test_overlapping_delimiter();
        test_random_buffers();
        test_unbroken_stream();

        $display("Checked %0d tokens from %0d bytes in %0d buffers.", tokens_checked,
                 bytes_sent, buffers_sent);
        $display("Covered length codes 0 to 7, all-zero and all-one delimiters.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog against a stalled handshake.
    initial begin
        #40_000_000;
        $display("Timeout with %0d tokens still predicted.", pending_tokens.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
